### rtl/core/mhpq_pkg.sv
// shared types and codes for the max-heap priority queue
`default_nettype none
package mhpq_pkg;

	// operation codes
	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_EXTRACT = 2'd1;
	localparam logic [1:0] OP_CHANGE  = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_START,     // latch operands, check bounds
		CMD_GROW,      // claim the end slot for an insert
		CMD_RD_ROOT,   // read root for extract
		CMD_RD_LAST,   // read last entry as the moving key
		CMD_RD_UP,     // read parent
		CMD_MOVE_UP,   // parent drops into the hole
		CMD_RD_DN,     // read both children
		CMD_MOVE_DN,   // chosen child rises into the hole
		CMD_PLACE,     // moving key goes into the hole
		CMD_DONE       // load result register
	} cmd_t;

	typedef struct packed {
		logic bad;       // bounds check failed
		logic is_root;   // position is zero
		logic up_move;   // moving key strictly greater than parent
		logic dn_move;   // chosen child strictly greater than moving key
		logic moved_up;  // a sift up moved at least once
	} sts_t;

endpackage
`default_nettype wire

### rtl/core/max_heap_priority_queue.sv
// top level of the max-heap priority queue
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | kind, key_value, slot_index
//  out     | out_valid/out_stall| final_position, removed_key, status
//
// one item at a time; a refused or unused operation goes straight to the result,
// and otherwise levels (at most log2 of capacity) counts the moves of the key;
// each level is a memory read step and then a compare-and-move step.
// reset empties the heap at once; stored keys are left as they are.
// in_stall is high from acceptance until the result sits in the output
// register; a stalled result holds and blocks the next one.
`default_nettype none
module max_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] key_value,
	input  wire logic [9:0]         slot_index,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [9:0]              final_position,
	output logic signed [31:0]      removed_key,
	output logic [1:0]              status
);

	cmd_t cmd;
	sts_t sts;
	logic busy, go;

	assign in_stall = busy;
	assign go       = in_valid && !busy;

	// controller
	mhpq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .op(kind), .sts(sts),
		.res_busy(out_valid && out_stall), .cmd(cmd), .busy(busy)
	);

	// datapath
	mhpq_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .kind(kind),
		.key_value(key_value), .slot_index(slot_index), .sts(sts),
		.res_valid(out_valid), .res_take(out_valid && !out_stall),
		.final_position(final_position), .removed_key(removed_key),
		.status(status)
	);

	// a result only appears while an operation is under way
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(busy))
		else $error("result without operation");

	// no transfer is taken in while busy
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !go)
		else $error("transfer accepted while busy");

	// a start always leaves idle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> busy)
		else $error("start lost");

endmodule
`default_nettype wire

### rtl/core/mhpq_ctrl.sv
// controller sequencing each heap operation
`default_nettype none
module mhpq_ctrl
	import mhpq_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [1:0] op,
	input  wire sts_t       sts,
	input  wire logic       res_busy,
	output cmd_t            cmd,
	output logic            busy
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_GROW, S_RROOT, S_RLAST,
		S_UPR, S_UPC, S_DNR, S_DNC, S_PLACE, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] op_q;
	logic to_dn;

	// a change that never moved up goes on down
	assign to_dn = (op_q == OP_CHANGE) && !sts.moved_up;

	// command decode
	always_comb begin
		unique case (state_q)
			S_IDLE:  cmd = go ? CMD_START : CMD_NONE;
			S_GROW:  cmd = CMD_GROW;
			S_RROOT: cmd = CMD_RD_ROOT;
			S_RLAST: cmd = CMD_RD_LAST;
			S_UPR:   cmd = CMD_RD_UP;
			S_UPC:   cmd = sts.up_move ? CMD_MOVE_UP : CMD_NONE;
			S_DNR:   cmd = CMD_RD_DN;
			S_DNC:   cmd = sts.dn_move ? CMD_MOVE_DN : CMD_NONE;
			S_PLACE: cmd = CMD_PLACE;
			S_DONE:  cmd = res_busy ? CMD_NONE : CMD_DONE;
			default: cmd = CMD_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
		end else begin
			unique case (state_q)
				S_IDLE: if (go) begin
					op_q    <= op;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.bad) state_q <= S_DONE;
					else if (op_q == OP_EXTRACT) state_q <= S_RROOT;
					else if (op_q == OP_INSERT) state_q <= S_GROW;
					else state_q <= S_UPR;
				end
				S_GROW:  state_q <= S_UPR;
				S_RROOT: state_q <= S_RLAST;
				S_RLAST: state_q <= S_DNR;
				S_UPR: begin
					if (sts.is_root) state_q <= to_dn ? S_DNR : S_PLACE;
					else state_q <= S_UPC;
				end
				S_UPC: begin
					if (sts.up_move) state_q <= S_UPR;
					else state_q <= to_dn ? S_DNR : S_PLACE;
				end
				S_DNR:   state_q <= S_DNC;
				S_DNC:   state_q <= sts.dn_move ? S_DNR : S_PLACE;
				S_PLACE: state_q <= S_DONE;
				S_DONE: if (!res_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/mhpq_dp.sv
// heap memory, position arithmetic and result register
`default_nettype none
module mhpq_dp
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = 1024,
	parameter int KEY_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  cmd_t                     cmd,
	input  wire logic [1:0]          kind,
	input  wire logic signed [31:0]  key_value,
	input  wire logic [9:0]          slot_index,
	output sts_t                     sts,
	output logic                     res_valid,
	input  wire logic                res_take,
	output logic [9:0]               final_position,
	output logic signed [31:0]       removed_key,
	output logic [1:0]               status
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KIN = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int PW = AW + 2;
	localparam int SW = (CW > 10) ? CW : 10;

	logic signed [KEY_BITS-1:0] mem [CAPACITY];
	logic signed [KEY_BITS-1:0] rd_a_q, rd_b_q, rd_c_q, key_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] pos_q;
	logic [1:0]    st_q;
	logic          bad_q, moved_q;
	logic signed [31:0] rem_q;

	// position arithmetic
	logic [PW-1:0] left_w, right_w;
	logic [AW-1:0] par_w, start_w, pick_w;
	logic          has_l, has_r, pick_r, range_bad;
	logic signed [KEY_BITS-1:0] key_in, child_w;

	assign left_w    = {1'b0, pos_q, 1'b1};
	assign right_w   = {1'b0, pos_q, 1'b0} + PW'(2);
	assign par_w     = AW'((pos_q - AW'(1)) >> 1);
	assign has_l     = left_w < PW'(count_q);
	assign has_r     = right_w < PW'(count_q);
	assign key_in    = KEY_BITS'($signed(key_value[KIN-1:0]));
	assign start_w   = (kind == OP_INSERT) ? AW'(count_q) : AW'(slot_index);
	assign range_bad = SW'(slot_index) >= SW'(count_q);

	// larger child, left wins ties
	assign pick_r  = has_r && (rd_c_q > rd_b_q);
	assign pick_w  = pick_r ? AW'(right_w) : AW'(left_w);
	assign child_w = pick_r ? rd_c_q : rd_b_q;

	// status towards the controller
	always_comb begin
		sts.bad      = bad_q;
		sts.is_root  = (pos_q == '0);
		sts.up_move  = key_q > rd_b_q;
		sts.dn_move  = has_l && (child_w > key_q);
		sts.moved_up = moved_q;
	end

	// memory: one write, up to two registered reads per cycle
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_MOVE_UP: mem[pos_q] <= rd_b_q;
			CMD_MOVE_DN: mem[pos_q] <= child_w;
			CMD_PLACE:   mem[pos_q] <= key_q;
			default: ;
		endcase
		unique case (cmd)
			CMD_START:   key_q  <= key_in;
			CMD_RD_ROOT: rd_a_q <= mem[0];
			CMD_RD_LAST: key_q  <= mem[AW'(count_q)];
			CMD_RD_UP:   rd_b_q <= mem[par_w];
			CMD_RD_DN: begin
				rd_b_q <= mem[AW'(left_w)];
				rd_c_q <= mem[AW'(right_w)];
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			pos_q          <= '0;
			st_q           <= ST_OK;
			bad_q          <= 1'b0;
			moved_q        <= 1'b0;
			res_valid      <= 1'b0;
			rem_q          <= '0;
			final_position <= '0;
			removed_key    <= '0;
			status         <= ST_OK;
		end else begin
			// a new result wins over a transfer in the same cycle
			priority if (cmd == CMD_DONE) res_valid <= 1'b1;
			else if (res_take) res_valid <= 1'b0;
			else res_valid <= res_valid;
			unique case (cmd)
				CMD_START: begin
					pos_q   <= start_w;
					moved_q <= 1'b0;
					rem_q   <= '0;
					priority if (kind == OP_INSERT) begin
						bad_q <= (count_q >= CW'(CAPACITY));
						st_q  <= (count_q >= CW'(CAPACITY)) ? ST_FULL : ST_OK;
					end else if (kind == OP_EXTRACT) begin
						bad_q <= (count_q == '0);
						st_q  <= (count_q == '0) ? ST_EMPTY : ST_OK;
					end else if (kind == OP_CHANGE) begin
						bad_q <= range_bad;
						st_q  <= range_bad ? ST_RANGE : ST_OK;
					end else begin
						bad_q <= 1'b1;
						st_q  <= ST_OK;
					end
				end
				CMD_GROW: count_q <= count_q + CW'(1);
				CMD_RD_ROOT: begin
					count_q <= count_q - CW'(1);
					pos_q   <= '0;
				end
				CMD_RD_LAST: rem_q <= 32'(rd_a_q);
				CMD_MOVE_UP: begin
					pos_q   <= par_w;
					moved_q <= 1'b1;
				end
				CMD_MOVE_DN: pos_q <= pick_w;
				CMD_DONE: begin
					final_position <= bad_q ? 10'd0 : 10'(pos_q);
					removed_key    <= rem_q;
					status         <= st_q;
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

### bench/heap_checker.sv
// checker for the max-heap priority queue: watches both channels, predicts and compares results
module heap_checker
	import mhpq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic signed [31:0] key_value,
	input  wire logic [9:0]         slot_index,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic [9:0]         final_position,
	input  wire logic signed [31:0] removed_key,
	input  wire logic [1:0]         status,
	output int                      mismatches,
	output int                      pending,
	output int                      results_seen
);

	localparam int EXP_DEPTH = 16;

	typedef struct packed {
		logic [9:0]         pos;
		logic signed [31:0] removed;
		logic [1:0]         st;
	} heap_result_t;

	logic signed [31:0] model_keys [1024];
	int unsigned        model_count;
	heap_result_t       expected_fifo [EXP_DEPTH];
	int unsigned        exp_wr;
	int unsigned        exp_rd;

	// move the key at pos towards the root while it beats its parent
	function automatic int unsigned bubble_up(int unsigned pos);
		int unsigned        parent;
		logic signed [31:0] tmp;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!(model_keys[pos] > model_keys[parent]))
				break;
			tmp = model_keys[pos];
			model_keys[pos] = model_keys[parent];
			model_keys[parent] = tmp;
			pos = parent;
		end
		return pos;
	endfunction

	// move the key at pos down towards the larger child, left wins ties
	function automatic int unsigned bubble_down(int unsigned pos);
		int unsigned        left;
		int unsigned        right;
		int unsigned        pick;
		logic signed [31:0] tmp;
		forever begin
			left = 2 * pos + 1;
			right = 2 * pos + 2;
			if (left >= model_count)
				break;
			pick = left;
			if (right < model_count && model_keys[right] > model_keys[left])
				pick = right;
			if (!(model_keys[pick] > model_keys[pos]))
				break;
			tmp = model_keys[pos];
			model_keys[pos] = model_keys[pick];
			model_keys[pick] = tmp;
			pos = pick;
		end
		return pos;
	endfunction

	// apply one operation to the model heap and give its result
	function automatic heap_result_t heap_operation(logic [1:0] op, logic signed [31:0] key,
			logic [9:0] slot);
		heap_result_t r;
		int unsigned  p;
		r = '0;
		case (op)
			OP_INSERT: begin
				if (model_count >= 1024) begin
					r.st = ST_FULL;
				end else begin
					model_keys[model_count] = key;
					model_count++;
					r.pos = 10'(bubble_up(model_count - 1));
				end
			end
			OP_EXTRACT: begin
				if (model_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.removed = model_keys[0];
					model_count--;
					model_keys[0] = model_keys[model_count];
					r.pos = 10'(bubble_down(0));
				end
			end
			OP_CHANGE: begin
				if (slot >= model_count) begin
					r.st = ST_RANGE;
				end else begin
					model_keys[slot] = key;
					p = bubble_up(slot);
					if (p == slot)
						p = bubble_down(slot);
					r.pos = 10'(p);
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	assign pending = int'(exp_wr - exp_rd);

	// predict on each input transfer, compare on each output transfer
	always @(posedge clk or negedge arst_n) begin
		heap_result_t want;
		if (!arst_n) begin
			model_count = 0;
			exp_wr = 0;
			exp_rd = 0;
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_fifo[exp_wr % EXP_DEPTH] = heap_operation(kind, key_value, slot_index);
				exp_wr++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (exp_wr == exp_rd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: pos %0d removed %0d status %0d",
							final_position, removed_key, status);
				end else begin
					want = expected_fifo[exp_rd % EXP_DEPTH];
					exp_rd++;
					if (want.pos !== final_position || want.removed !== removed_key ||
							want.st !== status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want pos %0d rem %0d st %0d, got %0d %0d %0d",
								want.pos, want.removed, want.st,
								final_position, removed_key, status);
					end
				end
			end
		end
	end

endmodule

### bench/max_heap_priority_queue_tb.sv
// testbench top for the max-heap priority queue: stimulus, back-pressure and verdict
module max_heap_priority_queue_tb;
	import mhpq_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         kind;
	logic signed [31:0] key_value;
	logic [9:0]         slot_index;
	logic               out_valid;
	logic               out_stall;
	logic [9:0]         final_position;
	logic signed [31:0] removed_key;
	logic [1:0]         status;
	int                 mismatches;
	int                 pending;
	int                 results_seen;

	int                 send_idle_pct;
	int                 stall_pct;
	int                 held;
	int                 sent;
	int                 full_hits;

	max_heap_priority_queue i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key_value(key_value), .slot_index(slot_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.final_position(final_position), .removed_key(removed_key), .status(status)
	);

	heap_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .key_value(key_value), .slot_index(slot_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.final_position(final_position), .removed_key(removed_key), .status(status),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard limit on run length
	initial begin
		#(12 * 1500000);
		$display("== FAIL ==");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// idling mode follows the transfer count
	function automatic void pick_idling(int n);
		case ((n / 120) % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 52; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 52; end
			default: begin send_idle_pct = 19; stall_pct = 19; end
		endcase
	endfunction

	// one input transfer with optional leading gap
	task automatic send_op(logic [1:0] op, logic signed [31:0] key, logic [9:0] slot);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		key_value <= key;
		slot_index <= slot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// track occupancy for biasing
		if (op == OP_INSERT) begin
			if (held < 1024)
				held++;
			else
				full_hits++;
		end else if (op == OP_EXTRACT && held > 0) begin
			held--;
		end
		sent++;
		pick_idling(sent);
	endtask

	function automatic logic signed [31:0] rand_key();
		int r;
		r = $urandom_range(7);
		if (r < 2)
			return $signed($urandom_range(16)) - 8;
		if (r == 2)
			return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom;
	endfunction

	function automatic logic [9:0] rand_slot();
		if (held > 0 && $urandom_range(9) < 8)
			return 10'($urandom_range(held - 1));
		return 10'($urandom);
	endfunction

	// weights in percent for insert, extract and change; the rest is the unused code
	task automatic random_op(int w_ins, int w_ext, int w_chg);
		int r;
		logic [1:0] op;
		r = $urandom_range(99);
		if (r < w_ins)
			op = OP_INSERT;
		else if (r < w_ins + w_ext)
			op = OP_EXTRACT;
		else if (r < w_ins + w_ext + w_chg)
			op = OP_CHANGE;
		else
			op = OP_NONE;
		send_op(op, rand_key(), rand_slot());
	endtask

	// stimulus
	initial begin
		int wait_cycles;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = OP_INSERT;
		key_value = '0;
		slot_index = '0;
		held = 0;
		sent = 0;
		full_hits = 0;
		pick_idling(0);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty, range, unused code, single entry, extremes, ties
		send_op(OP_EXTRACT, 0, 0);
		send_op(OP_CHANGE, 5, 0);
		send_op(OP_NONE, 32'sh7fffffff, 10'h3ff);
		send_op(OP_INSERT, 5, 0);
		send_op(OP_EXTRACT, 0, 0);
		send_op(OP_INSERT, 32'sh7fffffff, 0);
		send_op(OP_INSERT, 32'sh80000000, 0);
		send_op(OP_INSERT, 0, 0);
		send_op(OP_INSERT, -1, 0);
		send_op(OP_INSERT, 7, 0);
		send_op(OP_INSERT, 7, 0);
		send_op(OP_CHANGE, 32'sh7fffffff, 3);
		send_op(OP_CHANGE, 32'sh80000000, 0);
		send_op(OP_CHANGE, 7, 2);
		send_op(OP_CHANGE, 1, 10'h3ff);
		repeat (7) send_op(OP_EXTRACT, 0, 0);

		// mixed traffic
		repeat (130) random_op(40, 30, 25);
		// fill to capacity and push against the full heap
		while (held < 1024 || full_hits < 15)
			random_op(95, 2, 3);
		// extract-heavy traffic on the full heap
		repeat (110) random_op(15, 65, 17);
		in_valid <= 1'b0;

		// wait for outstanding results, then a settling margin
		wait_cycles = 0;
		while (pending != 0) begin
			@(posedge clk);
			wait_cycles++;
			if (wait_cycles > 200000) begin
				$display("== FAIL ==");
				$finish;
			end
		end
		repeat (60) @(posedge clk);

		$display("ran %0d operations, %0d results checked, %0d inserts refused as full",
			sent, results_seen, full_hits);
		$display("idling phases: none, sender gaps, receiver stalls, both together");
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sim.f
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_ctrl.sv
rtl/core/mhpq_dp.sv
rtl/core/max_heap_priority_queue.sv
bench/heap_checker.sv
bench/max_heap_priority_queue_tb.sv
